FILE: rtl/lcd4_pkg.sv
`timescale 1ns / 1ps

package lcd4_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_CURSOR = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       rs;
  } desc_t;

  localparam logic [15:0] EN_HIGH_US    = 16'd1;
  localparam logic [15:0] EN_LOW_US     = 16'd40;
  localparam logic [15:0] POWER_UP_US   = 16'd50000;
  localparam logic [15:0] INIT_WAIT_US  = 16'd5000;
  localparam logic [15:0] CLEAR_WAIT_US = 16'd2000;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_DDRAM  = 8'h80;
  localparam logic       ROW1_BIT   = 1'b1;

  localparam logic [4:0] INIT_LAST_STEP = 5'd24;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd4;

  localparam logic [9:0] CYCLES_PER_US_RST = 10'd72;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h33;
      3'd1:    v = 8'h32;
      3'd2:    v = 8'h28;
      3'd3:    v = 8'h0C;
      3'd4:    v = 8'h06;
      default: v = CMD_CLEAR;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/char_lcd_4bit_write_sequencer.sv
`timescale 1ns / 1ps

// Character LCD 4-bit bus sequencer.
// Input channel (in_valid/in_stall): one word per request, in_operation selects
// init, clear, set cursor or write character; in_char_byte, in_row and
// in_column carry the operands.
// Output channel (out_valid/out_stall): one word per pin event with the nibble
// for D4..D7, RS, EN, the hold time in microseconds and a last flag on the
// final event of each request.
// cfg_wr_en/cfg_wr_data load cycles_per_us; hold times are reported in
// microseconds, so it does not alter the event stream.
// When the block is empty, a request's first event passes the input register,
// queue, generator descriptor register and event register. Throughput: the
// event generator emits one event per cycle unless out_stall holds it, so
// clear, set cursor and write character expand to 4 events each and init to
// 25; a two-deep queue lets requests enter while earlier ones still expand.
// Reset clears the input register, queue and event generator; cycles_per_us
// returns to 72. While out_stall is high and an event is valid, that event is
// held and the generator pauses; the queue fills and then in_stall rises.

module char_lcd_4bit_write_sequencer
  import lcd4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_byte,
  input  logic        in_row,
  input  logic [5:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_nibble,
  output logic        out_reg_select,
  output logic        out_enable,
  output logic [15:0] out_hold_us,
  output logic        out_last
);

  logic [9:0] cycles_per_us_r;
  logic       f_push, f_ready;
  desc_t      f_desc;
  logic       q_valid, q_pop;
  desc_t      q_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_per_us_r <= CYCLES_PER_US_RST;
    end else if (cfg_wr_en) begin
      cycles_per_us_r <= cfg_wr_data;
    end
  end

  lcd4_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_char_byte (in_char_byte),
    .in_row       (in_row),
    .in_column    (in_column),
    .push         (f_push),
    .push_desc    (f_desc),
    .push_ready   (f_ready)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_desc  (f_desc),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_desc   (q_desc),
    .pop        (q_pop)
  );

  lcd4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_desc         (q_desc),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_enable     (out_enable),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/lcd4_front.sv
`timescale 1ns / 1ps

module lcd4_front
  import lcd4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_byte,
  input  logic       in_row,
  input  logic [5:0] in_column,
  output logic       push,
  output desc_t      push_desc,
  input  logic       push_ready
);

  logic  fv_r, fv_nxt;
  desc_t desc_r;
  desc_t desc_c;
  logic  accept;
  logic [6:0] addr;

  assign in_stall = fv_r & ~push_ready;
  assign accept   = in_valid & ~in_stall;
  assign push      = fv_r;
  assign push_desc = desc_r;

  // DDRAM address: row base in bit 6 plus column, never reaches bit 7
  assign addr = {in_row & ROW1_BIT, 6'd0} + {1'b0, in_column};

  always_comb begin
    desc_c.op = op_t'(in_operation);
    unique case (op_t'(in_operation))
      OP_INIT: begin
        desc_c.data = CMD_CLEAR;
        desc_c.rs   = 1'b0;
      end
      OP_CLEAR: begin
        desc_c.data = CMD_CLEAR;
        desc_c.rs   = 1'b0;
      end
      OP_CURSOR: begin
        desc_c.data = CMD_DDRAM | {1'b0, addr};
        desc_c.rs   = 1'b0;
      end
      default: begin
        desc_c.data = in_char_byte;
        desc_c.rs   = 1'b1;
      end
    endcase
  end

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_c;
    end
  end

endmodule

FILE: rtl/lcd4_queue.sv
`timescale 1ns / 1ps

module lcd4_queue
  import lcd4_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  push_ready,
  output logic  pop_valid,
  output desc_t pop_desc,
  input  logic  pop
);

  desc_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: rtl/lcd4_back.sv
`timescale 1ns / 1ps

module lcd4_back
  import lcd4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  desc_t       q_desc,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_nibble,
  output logic        out_reg_select,
  output logic        out_enable,
  output logic [15:0] out_hold_us,
  output logic        out_last
);

  logic        busy_r, busy_nxt;
  desc_t       desc_r;
  logic [4:0]  step_r, step_nxt;
  logic        ov_r, ov_nxt;
  logic [3:0]  nib_r;
  logic        rs_r, en_r, last_r;
  logic [15:0] hold_r;

  logic        is_init;
  logic        advance;
  logic        ev_last;
  logic [4:0]  j;
  logic [7:0]  byte_v;
  logic [3:0]  ev_nib;
  logic        ev_rs, ev_en;
  logic [15:0] ev_hold, extra;

  assign out_valid      = ov_r;
  assign out_nibble     = nib_r;
  assign out_reg_select = rs_r;
  assign out_enable     = en_r;
  assign out_hold_us    = hold_r;
  assign out_last       = last_r;

  assign is_init = (desc_r.op == OP_INIT);
  assign advance = busy_r & (~ov_r | ~out_stall);
  assign ev_last = (step_r == (is_init ? INIT_LAST_STEP : BYTE_LAST_STEP));
  assign q_pop   = q_valid & (~busy_r | (advance & ev_last));
  assign j       = step_r - 5'd1;
  assign byte_v  = is_init ? init_cmd(j[4:2]) : desc_r.data;

  always_comb begin
    extra = 16'd0;
    if (j[1:0] == 2'd3) begin
      if (is_init) begin
        if (j[4:2] == 3'd0 || j[4:2] == 3'd1) begin
          extra = INIT_WAIT_US;
        end else if (j[4:2] == 3'd5) begin
          extra = CLEAR_WAIT_US;
        end
      end else if (desc_r.op == OP_CLEAR) begin
        extra = CLEAR_WAIT_US;
      end
    end
    if (step_r == 5'd0) begin
      ev_nib  = 4'd0;
      ev_rs   = 1'b0;
      ev_en   = 1'b0;
      ev_hold = POWER_UP_US;
    end else begin
      ev_nib  = j[1] ? byte_v[3:0] : byte_v[7:4];
      ev_rs   = desc_r.rs;
      ev_en   = ~j[0];
      ev_hold = (j[0] ? EN_LOW_US : EN_HIGH_US) + extra;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    ov_nxt   = ov_r & out_stall;
    if (advance) begin
      ov_nxt   = 1'b1;
      step_nxt = step_r + 5'd1;
      if (ev_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = (q_desc.op == OP_INIT) ? 5'd0 : 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 5'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_desc;
    end
    if (advance) begin
      nib_r  <= ev_nib;
      rs_r   <= ev_rs;
      en_r   <= ev_en;
      hold_r <= ev_hold;
      last_r <= ev_last;
    end
  end

endmodule
